/* src/egcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended gcd unit: divider control flags (start, busy, done).
// ----------------------------------------------------------------------------
package egcd_pkg;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage
`default_nettype wire

/* src/egcd_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_div
// Restoring divider, one quotient bit per cycle.
// Takes the dividend and divisor on start.
// Returns the quotient and remainder when done is raised.
// ----------------------------------------------------------------------------
module egcd_div #(
  parameter int W = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [W-1:0]    dividend,
  input  wire logic [W-1:0]    divisor,
  output egcd_pkg::div_ctrl_t  ctrl,
  output logic      [W-1:0]    quotient,
  output logic      [W-1:0]    remainder
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {remainder, quotient[W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        remainder <= diff[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= trial[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b0};
      end
    end
  end

  assign ctrl = {start, busy, done};
endmodule
`default_nettype wire

/* src/egcd_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_mac
// Shift-add multiply-accumulate, one bit of q per cycle: acc + q*m.
// Used twice per step (s, t) under the sequencer.
// ----------------------------------------------------------------------------
module egcd_mac #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] q,
  input  wire logic [W-1:0] m,
  input  wire logic [W-1:0] acc_in,
  output logic              done,
  output logic      [W-1:0] acc
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic          busy;
  logic [W-1:0]  qs;
  logic [W-1:0]  ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1) || qs[W-1:1] == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= acc_in;
      qs  <= q;
      ms  <= m;
    end else if (busy) begin
      if (qs[0]) begin
        acc <= acc + ms;
      end
      qs <= qs >> 1;
      ms <= ms << 1;
    end
  end
endmodule
`default_nettype wire

/* src/extended_gcd_bezout_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// extended_gcd_bezout_unit
// Extended Euclid: gcd and Bezout coefficients of two unsigned operands.
// ----------------------------------------------------------------------------
// Sequence: per Euclid step, a check, a bit-serial divide and two
//   multiply-accumulate passes, each ending early once the quotient runs out;
//   the operands are loaded first, and a final check comes before the report.
// Throughput: one transaction at a time; the next is taken after the result
//   leaves. The bit-serial divider and the shared multiply-accumulate set it.
// Reset: synchronous, clears the sequencer; no state is kept across items.
module extended_gcd_bezout_unit #(
  parameter int OPERAND_WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OPERAND_WIDTH-1:0] operand_a,
  input  wire logic [OPERAND_WIDTH-1:0] operand_b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [OPERAND_WIDTH-1:0] divisor,
  output logic signed [OPERAND_WIDTH-1:0] coef_a,
  output logic signed [OPERAND_WIDTH-1:0] coef_b
);
  localparam int W = OPERAND_WIDTH;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MS   = 3'd2;
  localparam logic [2:0] ST_MT   = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]   state;
  logic [W-1:0] r_prev, r_cur, s_prev, s_cur, t_prev, t_cur, q, rem;
  logic         odd;
  logic         div_start, mac_start, mac_done;
  logic [W-1:0] mac_m, mac_acc_in, mac_acc, div_q, div_r;
  egcd_pkg::div_ctrl_t div_ctrl;
  logic         launched;

  egcd_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(r_prev),
    .divisor(r_cur), .ctrl(div_ctrl), .quotient(div_q), .remainder(div_r)
  );

  egcd_mac #(.W(W)) u_mac (
    .clk(clk), .rst(rst), .start(mac_start), .q(q), .m(mac_m),
    .acc_in(mac_acc_in), .done(mac_done), .acc(mac_acc)
  );

  assign mac_m      = (state == ST_MS) ? s_cur : t_cur;
  assign mac_acc_in = (state == ST_MS) ? s_prev : t_prev;
  assign div_start  = (state == ST_DIV) && !launched;
  assign mac_start  = (state == ST_MS || state == ST_MT) && !launched;
  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) state <= ST_CHK;
        ST_CHK:  state <= (r_cur == '0) ? ST_OUT : ST_DIV;
        ST_DIV: begin
          launched <= 1'b1;
          if (div_ctrl.done) begin
            launched <= 1'b0;
            state    <= ST_MS;
          end
        end
        ST_MS: begin
          launched <= 1'b1;
          if (mac_done) begin
            launched <= 1'b0;
            state    <= ST_MT;
          end
        end
        ST_MT: begin
          launched <= 1'b1;
          if (mac_done) begin
            launched <= 1'b0;
            state    <= ST_CHK;
          end
        end
        ST_OUT:  if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      r_prev <= operand_a;
      r_cur  <= operand_b;
      s_prev <= W'(1);
      s_cur  <= '0;
      t_prev <= '0;
      t_cur  <= W'(1);
      odd    <= 1'b0;
    end
    if (state == ST_DIV && div_ctrl.done) begin
      q   <= div_q;
      rem <= div_r;
    end
    if (state == ST_MS && launched && mac_done) begin
      s_prev <= s_cur;
      s_cur  <= mac_acc;
    end
    if (state == ST_MT && launched && mac_done) begin
      t_prev <= t_cur;
      t_cur  <= mac_acc;
      r_prev <= r_cur;
      r_cur  <= rem;
      odd    <= !odd;
    end
  end

  assign divisor = r_prev;
  assign coef_a  = odd ? -s_prev : s_prev;
  assign coef_b  = odd ? t_prev : -t_prev;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(divisor))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready while result pending");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.busy |-> state == ST_DIV)
    else $error("divider busy outside divide step");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the extended gcd unit: directed corner operands and
// random pairs of several shapes go in through a randomly idling sender; a
// randomly stalling receiver takes gcd and Bezout coefficients, and each one
// is compared with a behavioral Euclid recurrence.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int W          = 64;
  localparam int N_RANDOM   = 800;
  localparam int LONG_HOLD  = 3000;
  localparam int SETTLE     = 20000;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  typedef struct {
    logic [W-1:0] g;
    logic [W-1:0] s;
    logic [W-1:0] t;
  } bezout_t;

  class bezout_scoreboard;
    bezout_t pending_q[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    // Euclid on magnitudes; signs follow the parity of the step count.
    function bezout_t solve_bezout(logic [W-1:0] a, logic [W-1:0] b);
      logic [W-1:0] r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
      bit odd;
      bezout_t res;
      r0 = a; r1 = b; s0 = W'(1); s1 = '0; t0 = '0; t1 = W'(1); odd = 1'b0;
      while (r1 != 0) begin
        q  = r0 / r1;
        rn = r0 - q * r1;
        sn = s0 + q * s1;
        tn = t0 + q * t1;
        r0 = r1; r1 = rn;
        s0 = s1; s1 = sn;
        t0 = t1; t1 = tn;
        odd = !odd;
      end
      res.g = r0;
      res.s = odd ? -s0 : s0;
      res.t = odd ? t0 : -t0;
      return res;
    endfunction

    function void note_operands(logic [W-1:0] a, logic [W-1:0] b);
      pending_q.push_back(solve_bezout(a, b));
    endfunction

    function void check_result(logic [W-1:0] g, logic [W-1:0] s, logic [W-1:0] t);
      bezout_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result g=%h s=%h t=%h", $time, g, s, t);
        return;
      end
      e = pending_q.pop_front();
      if (g !== e.g) begin
        errors++;
        $display("%0t: divisor exp %h got %h", $time, e.g, g);
      end
      if (s !== e.s) begin
        errors++;
        $display("%0t: coef_a exp %0d got %0d", $time, $signed(e.s), $signed(s));
      end
      if (t !== e.t) begin
        errors++;
        $display("%0t: coef_b exp %0d got %0d", $time, $signed(e.t), $signed(t));
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         in_valid = 0;
  logic         in_ready;
  logic [W-1:0] operand_a = '0;
  logic [W-1:0] operand_b = '0;
  logic         out_valid;
  logic         out_ready = 0;
  logic [W-1:0] divisor;
  logic [W-1:0] coef_a;
  logic [W-1:0] coef_b;

  bezout_scoreboard sb = new();
  bit     hold_request = 0;
  longint cycle_cnt = 0;

  extended_gcd_bezout_unit #(.OPERAND_WIDTH(W)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .divisor(divisor), .coef_a(coef_a), .coef_b(coef_b)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_operands(operand_a, operand_b);
    if (!rst && out_valid && out_ready) sb.check_result(divisor, coef_a, coef_b);
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid && !hold_request);
    end
  end

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // random value of random bit length
  function automatic logic [W-1:0] rand_sized();
    return rand_word() >> $urandom_range(0, W - 1);
  endfunction

  task automatic send_pair(logic [W-1:0] a, logic [W-1:0] b, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait first so the monitor has logged the last accepted transaction
  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [W-1:0] a, b, k;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners
    send_pair(64'd0, 64'd0);
    send_pair(64'd12345, 64'd0);
    send_pair('1, 64'd0);
    send_pair(64'd0, 64'd987654321);
    send_pair(64'd0, '1);
    send_pair('1, '1);
    send_pair('1, 64'd1);
    send_pair(64'd1, '1);
    send_pair('1, '1 - 64'd1);
    send_pair(64'd12200160415121876738, 64'd7540113804746346429);
    send_pair(64'd7540113804746346429, 64'd12200160415121876738);
    send_pair(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_pair(64'd240, 64'd46);
    send_pair(64'd17, 64'd17);
    send_pair(64'd3, 64'd1_000_000_007);
    send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    drain_results();

    hold_request = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 5))
        0: begin a = rand_word(); b = rand_word(); end
        1: begin a = rand_sized(); b = rand_sized(); end
        2: begin
          k = rand_word() >> $urandom_range(32, W - 1);
          a = k * (rand_word() >> $urandom_range(40, W - 1));
          b = k * (rand_word() >> $urandom_range(40, W - 1));
        end
        3: begin
          a = W'($urandom_range(0, 300));
          b = W'($urandom_range(0, 300));
        end
        4: begin
          a = rand_sized();
          b = ($urandom_range(0, 1) == 0) ? '0 : a;
          if ($urandom_range(0, 1) == 0) begin
            k = a; a = b; b = k;
          end
        end
        default: begin a = rand_word(); b = rand_sized(); end
      endcase
      send_pair(a, b, hold_request);
      if (i == N_RANDOM / 2) drain_results();
    end
    drain_results();

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
